// File: rtl/ffba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator: field widths,
// status and mark codes, register indexes and the microcode control word.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int ADDR_W      = 32;
  localparam int CFG_COUNT_W = 11;
  localparam int CFG_DATA_W  = 32;
  localparam int STATUS_W    = 2;

  localparam logic [CFG_COUNT_W-1:0] COUNT_RESET = 11'd1024;

  // Register indexes on the configuration port.
  localparam logic REG_BASE  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  // Operation codes of an input item.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOMEM   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADADDR = 2'd2;

  // Bit positions inside one block mark.
  localparam int MARK_TAKEN = 0;
  localparam int MARK_NEXT  = 1;

  // Microprogram step counter width.
  localparam int STEP_W = 4;

  // Index counter operations.
  localparam logic [2:0] IDX_HOLD  = 3'd0;
  localparam logic [2:0] IDX_CLEAR = 3'd1;
  localparam logic [2:0] IDX_INC   = 3'd2;
  localparam logic [2:0] IDX_START = 3'd3;
  localparam logic [2:0] IDX_ADDR  = 3'd4;

  // Run counter operations.
  localparam logic [2:0] RUN_HOLD  = 3'd0;
  localparam logic [2:0] RUN_CLEAR = 3'd1;
  localparam logic [2:0] RUN_SCAN  = 3'd2;
  localparam logic [2:0] RUN_NEED  = 3'd3;
  localparam logic [2:0] RUN_DEC   = 3'd4;

  // Result register operations.
  localparam logic [2:0] RES_HOLD     = 3'd0;
  localparam logic [2:0] RES_NOMEM    = 3'd1;
  localparam logic [2:0] RES_BAD      = 3'd2;
  localparam logic [2:0] RES_OK_FREE  = 3'd3;
  localparam logic [2:0] RES_OK_ALLOC = 3'd4;

  // Jump conditions.
  localparam logic [3:0] C_NONE      = 4'd0;
  localparam logic [3:0] C_ALWAYS    = 4'd1;
  localparam logic [3:0] C_CLR_MORE  = 4'd2;
  localparam logic [3:0] C_NO_ITEM   = 4'd3;
  localparam logic [3:0] C_IS_FREE   = 4'd4;
  localparam logic [3:0] C_ALLOC_BAD = 4'd5;
  localparam logic [3:0] C_SCAN_END  = 4'd6;
  localparam logic [3:0] C_RUN_MISS  = 4'd7;
  localparam logic [3:0] C_RUN_MORE  = 4'd8;
  localparam logic [3:0] C_FREE_BAD  = 4'd9;
  localparam logic [3:0] C_WALK_MORE = 4'd10;
  localparam logic [3:0] C_OUT_FREE  = 4'd11;

  typedef struct packed {
    logic              in_ready;
    logic              mem_rd;
    logic              mem_wr;
    logic              wr_chain;
    logic              need_load;
    logic              out_load;
    logic [2:0]        idx_op;
    logic [2:0]        run_op;
    logic [2:0]        res_op;
    logic [3:0]        cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic item;
    logic is_free;
    logic clr_more;
    logic alloc_bad;
    logic scan_end;
    logic run_miss;
    logic run_more;
    logic free_bad;
    logic walk_more;
    logic out_free;
  } flags_t;

endpackage
`default_nettype wire

// File: rtl/ffba_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_seq
// Microprogram sequencer: a step counter, the control store and the
// conditional jump logic that selects the next step.
// ----------------------------------------------------------------------------
module ffba_seq import ffba_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire flags_t flags,
  output ctrl_t       ctrl
);

  localparam logic [STEP_W-1:0] STEP_CLR       = 4'd0;
  localparam logic [STEP_W-1:0] STEP_WAIT      = 4'd1;
  localparam logic [STEP_W-1:0] STEP_DISPATCH  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_ALLOC_CHK = 4'd3;
  localparam logic [STEP_W-1:0] STEP_SCAN_RD   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_SCAN_EV   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_WR_INIT   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_WR        = 4'd7;
  localparam logic [STEP_W-1:0] STEP_ALLOC_OK  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_FREE_CHK  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_FREE_RD   = 4'd10;
  localparam logic [STEP_W-1:0] STEP_FREE_WR   = 4'd11;
  localparam logic [STEP_W-1:0] STEP_DONE      = 4'd12;
  localparam logic [STEP_W-1:0] STEP_DONE_LOOP = 4'd13;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              take;

  function automatic ctrl_t microcode(input logic [STEP_W-1:0] s);
    ctrl_t c;
    c = '0;
    unique case (s)
      STEP_CLR: begin
        // Clearing pass over the mark table after reset.
        c.mem_wr = 1'b1;
        c.idx_op = IDX_INC;
        c.cond   = C_CLR_MORE;
        c.target = STEP_CLR;
      end
      STEP_WAIT: begin
        c.in_ready = 1'b1;
        c.idx_op   = IDX_CLEAR;
        c.run_op   = RUN_CLEAR;
        c.cond     = C_NO_ITEM;
        c.target   = STEP_WAIT;
      end
      STEP_DISPATCH: begin
        c.cond   = C_IS_FREE;
        c.target = STEP_FREE_CHK;
      end
      STEP_ALLOC_CHK: begin
        c.need_load = 1'b1;
        c.res_op    = RES_NOMEM;
        c.cond      = C_ALLOC_BAD;
        c.target    = STEP_DONE;
      end
      STEP_SCAN_RD: begin
        c.mem_rd = 1'b1;
        c.cond   = C_SCAN_END;
        c.target = STEP_DONE;
      end
      STEP_SCAN_EV: begin
        c.run_op = RUN_SCAN;
        c.idx_op = IDX_INC;
        c.cond   = C_RUN_MISS;
        c.target = STEP_SCAN_RD;
      end
      STEP_WR_INIT: begin
        c.idx_op = IDX_START;
        c.run_op = RUN_NEED;
      end
      STEP_WR: begin
        c.mem_wr   = 1'b1;
        c.wr_chain = 1'b1;
        c.idx_op   = IDX_INC;
        c.run_op   = RUN_DEC;
        c.cond     = C_RUN_MORE;
        c.target   = STEP_WR;
      end
      STEP_ALLOC_OK: begin
        c.res_op = RES_OK_ALLOC;
        c.cond   = C_ALWAYS;
        c.target = STEP_DONE;
      end
      STEP_FREE_CHK: begin
        c.res_op = RES_BAD;
        c.idx_op = IDX_ADDR;
        c.cond   = C_FREE_BAD;
        c.target = STEP_DONE;
      end
      STEP_FREE_RD: begin
        c.mem_rd = 1'b1;
        c.res_op = RES_OK_FREE;
      end
      STEP_FREE_WR: begin
        c.mem_wr = 1'b1;
        c.idx_op = IDX_INC;
        c.cond   = C_WALK_MORE;
        c.target = STEP_FREE_RD;
      end
      STEP_DONE: begin
        c.out_load = 1'b1;
        c.cond     = C_OUT_FREE;
        c.target   = STEP_WAIT;
      end
      STEP_DONE_LOOP: begin
        c.cond   = C_ALWAYS;
        c.target = STEP_DONE;
      end
      default: begin
        c.cond   = C_ALWAYS;
        c.target = STEP_WAIT;
      end
    endcase
    return c;
  endfunction

  assign ctrl = microcode(step);

  always_comb begin
    unique case (ctrl.cond)
      C_NONE:      take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_CLR_MORE:  take = flags.clr_more;
      C_NO_ITEM:   take = !flags.item;
      C_IS_FREE:   take = flags.is_free;
      C_ALLOC_BAD: take = flags.alloc_bad;
      C_SCAN_END:  take = flags.scan_end;
      C_RUN_MISS:  take = flags.run_miss;
      C_RUN_MORE:  take = flags.run_more;
      C_FREE_BAD:  take = flags.free_bad;
      C_WALK_MORE: take = flags.walk_more;
      C_OUT_FREE:  take = flags.out_free;
      default:     take = 1'b0;
    endcase
    step_next = take ? ctrl.target : step + STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_CLR;
    end else begin
      step <= step_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ffba_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_datapath
// Mark table, index and run counters, request registers and the result
// register, driven by one control word per cycle.
// ----------------------------------------------------------------------------
module ffba_datapath import ffba_pkg::*; #(
  parameter int BLOCK_BYTES = 4096,
  parameter int MAX_BLOCKS  = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire ctrl_t                  ctrl,
  output flags_t                      flags,
  input  wire logic [ADDR_W-1:0]      base_address,
  input  wire logic [CFG_COUNT_W-1:0] block_count,
  input  wire logic                   in_valid,
  input  wire logic                   operation,
  input  wire logic [ADDR_W-1:0]      size_bytes,
  input  wire logic [ADDR_W-1:0]      address,
  input  wire logic                   out_ready,
  output logic                        out_valid,
  output logic [ADDR_W-1:0]           address_res,
  output logic [STATUS_W-1:0]         status
);

  // BLOCK_BYTES must be a power of two; the block itself does not enforce it.
  localparam int SHIFT = $clog2(BLOCK_BYTES);
  localparam int AW    = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int NW    = ADDR_W - SHIFT + 1;
  localparam int CMP_W = (NW > CNT_W) ? NW : CNT_W;
  localparam logic [ADDR_W-1:0] LOW_MASK = ADDR_W'(BLOCK_BYTES - 1);

  logic [1:0]          marks [MAX_BLOCKS];
  logic [1:0]          rd_mark;
  logic [1:0]          wr_data;

  logic                op_q;
  logic [ADDR_W-1:0]   size_q;
  logic [ADDR_W-1:0]   addr_q;

  logic [CNT_W-1:0]    idx;
  logic [CNT_W-1:0]    run;
  logic [CNT_W-1:0]    need;
  logic [AW-1:0]       start;
  logic [ADDR_W-1:0]   res_addr;
  logic [STATUS_W-1:0] res_status;

  logic [CNT_W-1:0]    total;
  logic [ADDR_W-1:0]   heap_base;
  logic [ADDR_W-1:0]   addr_off;
  logic [ADDR_W-1:0]   off_idx;
  logic [NW-1:0]       n_blocks;
  logic                taken;
  logic                out_free;

  always_comb begin
    if (CMP_W'(block_count) > CMP_W'(MAX_BLOCKS)) begin
      total = CNT_W'(MAX_BLOCKS);
    end else begin
      total = CNT_W'(block_count);
    end
    heap_base = base_address & ~LOW_MASK;
    addr_off  = addr_q - heap_base;
    off_idx   = addr_off >> SHIFT;
    // Round the byte size up to whole blocks.
    n_blocks  = NW'(size_q >> SHIFT) + NW'(|(size_q & LOW_MASK));
    taken     = rd_mark[MARK_TAKEN];
    out_free  = !out_valid || out_ready;
    wr_data   = '0;
    if (ctrl.wr_chain) begin
      wr_data[MARK_TAKEN] = 1'b1;
      wr_data[MARK_NEXT]  = (run != CNT_W'(1));
    end
  end

  always_comb begin
    flags.item      = in_valid;
    flags.is_free   = (op_q == OP_FREE);
    flags.clr_more  = (idx != CNT_W'(MAX_BLOCKS - 1));
    flags.alloc_bad = (n_blocks == '0) || (CMP_W'(n_blocks) > CMP_W'(total));
    flags.scan_end  = (idx == total);
    flags.run_miss  = taken || (CNT_W'(run + CNT_W'(1)) != need);
    flags.run_more  = (run != CNT_W'(1));
    flags.free_bad  = (addr_q < heap_base) || (off_idx >= ADDR_W'(total));
    flags.walk_more = rd_mark[MARK_NEXT] && (CNT_W'(idx + CNT_W'(1)) != total);
    flags.out_free  = out_free;
  end

  // Mark table, one read or one write per cycle.
  always_ff @(posedge clk) begin
    if (ctrl.mem_wr) begin
      marks[idx[AW-1:0]] <= wr_data;
    end
    if (ctrl.mem_rd) begin
      rd_mark <= marks[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && ctrl.in_ready) begin
      op_q   <= operation;
      size_q <= size_bytes;
      addr_q <= address;
    end
    if (ctrl.need_load) begin
      need <= CNT_W'(n_blocks);
    end
    case (ctrl.run_op)
      RUN_CLEAR: run <= '0;
      RUN_SCAN: begin
        if (taken) begin
          run <= '0;
        end else begin
          // A free block after a taken one, or at the start of the scan, opens a new candidate run.
          if (run == '0) begin
            start <= idx[AW-1:0];
          end
          run <= run + CNT_W'(1);
        end
      end
      RUN_NEED: run <= need;
      RUN_DEC:  run <= run - CNT_W'(1);
      default:  run <= run;
    endcase
    case (ctrl.res_op)
      RES_NOMEM: begin
        res_addr   <= '0;
        res_status <= ST_NOMEM;
      end
      RES_BAD: begin
        res_addr   <= '0;
        res_status <= ST_BADADDR;
      end
      RES_OK_FREE: begin
        res_addr   <= '0;
        res_status <= ST_OK;
      end
      RES_OK_ALLOC: begin
        res_addr   <= heap_base + (ADDR_W'(start) << SHIFT);
        res_status <= ST_OK;
      end
      default: begin
        res_addr   <= res_addr;
        res_status <= res_status;
      end
    endcase
    if (ctrl.out_load && out_free) begin
      address_res <= res_addr;
      status      <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (ctrl.idx_op)
        IDX_CLEAR: idx <= '0;
        IDX_INC:   idx <= idx + CNT_W'(1);
        IDX_START: idx <= CNT_W'(start);
        IDX_ADDR:  idx <= CNT_W'(off_idx);
        default:   idx <= idx;
      endcase
      if (ctrl.out_load && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/first_fit_block_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap block allocator with a chained mark table.
// ----------------------------------------------------------------------------
// Requests enter on the in_valid/in_ready channel: operation 0 allocates
// size_bytes, operation 1 frees the chain that starts at address. Each item
// gives exactly one result on the out_valid/out_ready channel.
// After reset a clearing pass writes every mark table entry, one per cycle,
// and in_ready first rises once that pass is done.
// Configuration writes (config_write) are taken at any time, but are meant
// for an idle block.
// An allocate scans the mark table with one mark read and one evaluate step
// per block, then writes each block of the run it found; a scan that runs out
// of blocks, or a zero or oversized request, ends with no memory. A free walks
// its chain and clears each block of it, and a bad address is refused before
// any mark is read. The idle step comes between one item and the next.
// One item is in work at a time. The finished result sits in an output
// register; while the receiver stalls, the next item is still accepted and
// worked, and the sequencer holds in its final step until that register is
// taken.
// ----------------------------------------------------------------------------
module first_fit_block_allocator import ffba_pkg::*; #(
  parameter int BLOCK_BYTES = 4096,
  parameter int MAX_BLOCKS  = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  operation,
  input  wire logic [ADDR_W-1:0]     size_bytes,
  input  wire logic [ADDR_W-1:0]     address,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [ADDR_W-1:0]          address_res,
  output logic [STATUS_W-1:0]        status,
  input  wire logic                  config_write,
  input  wire logic                  config_index,
  input  wire logic [CFG_DATA_W-1:0] config_data
);

  ctrl_t                  ctrl;
  flags_t                 flags;
  logic [ADDR_W-1:0]      base_address;
  logic [CFG_COUNT_W-1:0] block_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      block_count  <= COUNT_RESET;
    end else if (config_write) begin
      case (config_index)
        REG_BASE:  base_address <= config_data;
        REG_COUNT: block_count  <= config_data[CFG_COUNT_W-1:0];
        default:   base_address <= base_address;
      endcase
    end
  end

  assign in_ready = ctrl.in_ready;

  ffba_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  ffba_datapath #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .MAX_BLOCKS  (MAX_BLOCKS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .flags        (flags),
    .base_address (base_address),
    .block_count  (block_count),
    .in_valid     (in_valid),
    .operation    (operation),
    .size_bytes   (size_bytes),
    .address      (address),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .address_res  (address_res),
    .status       (status)
  );

endmodule
`default_nettype wire
